// ===== rtl/drpi_pkg.sv =====
package drpi_pkg;

   // Field widths
   localparam int unsigned FWD_W     = 24;
   localparam int unsigned YAW_W     = 21;
   localparam int unsigned DT_W      = 16;
   localparam int unsigned POS_W     = 32;
   localparam int unsigned HEAD_W    = 19;
   localparam int unsigned START_W   = 12;
   localparam int unsigned REQ_W     = 64;
   localparam int unsigned RSP_W     = 88;

   // Datapath widths
   localparam int unsigned MUL_A_W   = 27;
   localparam int unsigned MUL_B_W   = 32;
   localparam int unsigned PROD_W    = MUL_A_W + MUL_B_W;
   localparam int unsigned WRAP_W    = 23;
   localparam int unsigned Z_W       = 28;
   localparam int unsigned VEC_W     = 32;
   localparam int unsigned MAX_STEPS = 24;
   localparam int unsigned ATAN_IDX_W = 5;

   // Configuration register indexes
   localparam int unsigned CSR_ADDR_W = 1;
   localparam logic [CSR_ADDR_W-1:0] CSR_START_X = 1'd0;
   localparam logic [CSR_ADDR_W-1:0] CSR_START_Y = 1'd1;

   localparam logic [START_W-1:0] START_X_RST = 12'd350;
   localparam logic [START_W-1:0] START_Y_RST = 12'd537;

   // Angle constants
   localparam logic signed [WRAP_W-1:0] PI_Q16      = 23'sd205888;
   localparam logic signed [WRAP_W-1:0] TWO_PI_Q16  = 23'sd411775;
   localparam logic signed [Z_W-1:0]    PI_Q24      = 28'sd52707179;
   localparam logic signed [Z_W-1:0]    HALF_PI_Q24 = 28'sd26353589;
   localparam logic signed [VEC_W-1:0]  GAIN_Q30    = 32'sd652032874;

   typedef struct packed {
      logic load;
      logic step;
   } drpi_cordic_ctrl_type;

   typedef enum logic [9:0] {
      ST_IDLE  = 10'b00_0000_0001,
      ST_HMUL  = 10'b00_0000_0010,
      ST_HDIFF = 10'b00_0000_0100,
      ST_WRAP  = 10'b00_0000_1000,
      ST_ROT   = 10'b00_0001_0000,
      ST_MULX  = 10'b00_0010_0000,
      ST_ACCX  = 10'b00_0100_0000,
      ST_MULY  = 10'b00_1000_0000,
      ST_ACCY  = 10'b01_0000_0000,
      ST_DONE  = 10'b10_0000_0000
   } drpi_state_type;

   function automatic logic signed [Z_W-1:0] atan_q24(input logic [ATAN_IDX_W-1:0] idx);
      logic signed [Z_W-1:0] val;
      unique case (idx)
         5'd0:    val = 28'sd13176795;
         5'd1:    val = 28'sd7778716;
         5'd2:    val = 28'sd4110060;
         5'd3:    val = 28'sd2086331;
         5'd4:    val = 28'sd1047215;
         5'd5:    val = 28'sd524118;
         5'd6:    val = 28'sd262123;
         5'd7:    val = 28'sd131070;
         5'd8:    val = 28'sd65536;
         5'd9:    val = 28'sd32768;
         5'd10:   val = 28'sd16384;
         5'd11:   val = 28'sd8192;
         5'd12:   val = 28'sd4096;
         5'd13:   val = 28'sd2048;
         5'd14:   val = 28'sd1024;
         5'd15:   val = 28'sd512;
         5'd16:   val = 28'sd256;
         5'd17:   val = 28'sd128;
         5'd18:   val = 28'sd64;
         5'd19:   val = 28'sd32;
         5'd20:   val = 28'sd16;
         5'd21:   val = 28'sd8;
         5'd22:   val = 28'sd4;
         5'd23:   val = 28'sd2;
         default: val = 28'sd0;
      endcase
      return val;
   endfunction

endpackage

// ===== rtl/drpi_mult.sv =====
module drpi_mult
   import drpi_pkg::*;
(
   input  logic                      clock,
   input  logic                      en,
   input  logic signed [MUL_A_W-1:0] a,
   input  logic signed [MUL_B_W-1:0] b,
   output logic signed [PROD_W-1:0]  prod_ff
);

   logic signed [PROD_W-1:0] prod_in;

   assign prod_in = PROD_W'(a) * PROD_W'(b);

   // hold product until the next operation
   always_ff @(posedge clock) begin
      if (en) begin
         prod_ff <= prod_in;
      end
   end

endmodule

// ===== rtl/drpi_cordic.sv =====
module drpi_cordic
   import drpi_pkg::*;
#(
   parameter int unsigned NSTEPS = 16
)
(
   input  logic                      clock,
   input  logic                      reset,
   input  drpi_cordic_ctrl_type      ctrl,
   input  logic signed [HEAD_W-1:0]  angle,
   output logic                      last_step,
   output logic signed [VEC_W-1:0]   cos_out,
   output logic signed [VEC_W-1:0]   sin_out
);

   localparam int unsigned CW = $clog2(NSTEPS);

   logic signed [VEC_W-1:0] x_ff, x_in;
   logic signed [VEC_W-1:0] y_ff, y_in;
   logic signed [Z_W-1:0]   z_ff, z_in;
   logic                    neg_ff, neg_in;
   logic [CW-1:0]           cnt_ff, cnt_in;

   logic signed [Z_W-1:0]   z_ext;
   logic signed [VEC_W-1:0] dx, dy;
   logic signed [Z_W-1:0]   atan_val;

   assign z_ext    = {{(Z_W-HEAD_W-8){angle[HEAD_W-1]}}, angle, 8'b0};
   assign dx       = y_ff >>> cnt_ff;
   assign dy       = x_ff >>> cnt_ff;
   assign atan_val = atan_q24(ATAN_IDX_W'(cnt_ff));

   assign last_step = (cnt_ff == CW'(NSTEPS - 1));
   assign cos_out   = neg_ff ? -x_ff : x_ff;
   assign sin_out   = neg_ff ? -y_ff : y_ff;

   always_comb begin
      x_in   = x_ff;
      y_in   = y_ff;
      z_in   = z_ff;
      neg_in = neg_ff;
      cnt_in = cnt_ff;
      if (ctrl.load) begin
         // fold the angle into [-pi/2, pi/2] and negate the result later
         x_in   = GAIN_Q30;
         y_in   = '0;
         cnt_in = '0;
         priority if (z_ext > HALF_PI_Q24) begin
            z_in   = z_ext - PI_Q24;
            neg_in = 1'b1;
         end else if (z_ext < -HALF_PI_Q24) begin
            z_in   = z_ext + PI_Q24;
            neg_in = 1'b1;
         end else begin
            z_in   = z_ext;
            neg_in = 1'b0;
         end
      end else if (ctrl.step) begin
         cnt_in = cnt_ff + 1'b1;
         if (!z_ff[Z_W-1]) begin
            x_in = x_ff - dx;
            y_in = y_ff + dy;
            z_in = z_ff - atan_val;
         end else begin
            x_in = x_ff + dx;
            y_in = y_ff - dy;
            z_in = z_ff + atan_val;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else begin
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      x_ff   <= x_in;
      y_ff   <= y_in;
      z_ff   <= z_in;
      neg_ff <= neg_in;
   end

endmodule

// ===== rtl/dead_reckoning_pose_integrator_core.sv =====
// A request accepted on req_tvalid/tready passes HMUL, HDIFF, WRAP, ROT (N CORDIC
// steps, N = min(CORDIC_STEPS, 24)), MULX, ACCX, MULY, ACCY and DONE to rsp_tvalid.
// Requests are taken only in IDLE, one at a time; the single CORDIC rotator
// iterates once per step and the shared multiplier is used three times.
// Reset (synchronous, active high) clears heading and position to zero and
// restores start_x = 350, start_y = 537.
module dead_reckoning_pose_integrator_core
   import drpi_pkg::*;
#(
   parameter int unsigned CORDIC_STEPS = 16
)
(
   input  logic                  clock,
   input  logic                  reset,
   // Input stream
   input  logic                  req_tvalid,
   output logic                  req_tready,
   // [23:0] forward_move, [44:24] yaw_rate, [60:45] time_step, [63:61] zero
   input  logic [REQ_W-1:0]      req_tdata,
   // Result stream
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // [31:0] map_x, [63:32] map_y, [82:64] heading, [87:83] zero
   output logic [RSP_W-1:0]      rsp_tdata,
   // Configuration write port
   input  logic                  csr_we,
   input  logic [CSR_ADDR_W-1:0] csr_addr,
   input  logic [START_W-1:0]    csr_wdata
);

   localparam int unsigned NSTEPS = (CORDIC_STEPS > MAX_STEPS) ? MAX_STEPS : CORDIC_STEPS;

   // ------------------------------------------------------------------
   // State
   // ------------------------------------------------------------------
   drpi_state_type state_ff, state_in;

   logic signed [HEAD_W-1:0]  heading_ff, heading_in;
   logic [POS_W-1:0]          rel_x_ff, rel_x_in;
   logic [POS_W-1:0]          rel_y_ff, rel_y_in;
   logic [START_W-1:0]        start_x_ff, start_x_in;
   logic [START_W-1:0]        start_y_ff, start_y_in;

   // Per-transaction operands
   logic signed [MUL_A_W-1:0] dist_ff, dist_in;   // forward_move * 5, Q.16 pixels
   logic signed [YAW_W-1:0]   yaw_ff, yaw_in;
   logic [DT_W-1:0]           dt_ff, dt_in;
   logic signed [WRAP_W-1:0]  wrap_ff, wrap_in;   // heading + pi - dt*yaw_rate, before modulo

   // Output register
   logic                      rsp_valid_ff, rsp_valid_in;
   logic [RSP_W-1:0]          rsp_data_ff, rsp_data_in;

   // ------------------------------------------------------------------
   // Shared multiplier and CORDIC rotator
   // ------------------------------------------------------------------
   logic signed [MUL_A_W-1:0] mul_a;
   logic signed [MUL_B_W-1:0] mul_b;
   logic                      mul_en;
   logic signed [PROD_W-1:0]  prod;

   drpi_cordic_ctrl_type      cordic_ctrl;
   logic                      cordic_last;
   logic signed [VEC_W-1:0]   cos_val, sin_val;

   logic signed [HEAD_W-1:0]  heading_new;

   drpi_mult u_mult (
      .clock   (clock),
      .en      (mul_en),
      .a       (mul_a),
      .b       (mul_b),
      .prod_ff (prod)
   );

   drpi_cordic #(
      .NSTEPS (NSTEPS)
   ) u_cordic (
      .clock     (clock),
      .reset     (reset),
      .ctrl      (cordic_ctrl),
      .angle     (heading_new),
      .last_step (cordic_last),
      .cos_out   (cos_val),
      .sin_out   (sin_val)
   );

   // ------------------------------------------------------------------
   // Datapath helpers
   // ------------------------------------------------------------------
   logic signed [PROD_W-1:0]  prod_r16, prod_r30;
   logic signed [WRAP_W-1:0]  head_step;
   logic [POS_W-1:0]          move_px;
   logic signed [FWD_W-1:0]   req_fwd;
   logic signed [MUL_A_W-1:0] req_fwd_ext;

   // round Q.32 -> Q.16 and Q.46 -> Q.16, floor after adding half
   assign prod_r16  = (prod + PROD_W'(64'sd32768)) >>> 16;
   assign prod_r30  = (prod + PROD_W'(64'sd536870912)) >>> 30;
   assign head_step = prod_r16[WRAP_W-1:0];
   assign move_px   = prod_r30[POS_W-1:0];

   assign heading_new = HEAD_W'(wrap_ff - PI_Q16);

   assign req_fwd     = req_tdata[FWD_W-1:0];
   assign req_fwd_ext = MUL_A_W'(req_fwd);

   assign req_tready = (state_ff == ST_IDLE);

   // ------------------------------------------------------------------
   // Sequencer
   // ------------------------------------------------------------------
   always_comb begin
      state_in     = state_ff;
      heading_in   = heading_ff;
      rel_x_in     = rel_x_ff;
      rel_y_in     = rel_y_ff;
      start_x_in   = start_x_ff;
      start_y_in   = start_y_ff;
      dist_in      = dist_ff;
      yaw_in       = yaw_ff;
      dt_in        = dt_ff;
      wrap_in      = wrap_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      mul_en       = 1'b0;
      mul_a        = MUL_A_W'($signed({1'b0, dt_ff}));
      mul_b        = MUL_B_W'(yaw_ff);
      cordic_ctrl  = '0;

      // drop the result once the downstream side takes it
      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end

      // configuration writes must arrive only while idle; the block does not enforce this
      if (csr_we) begin
         unique case (csr_addr)
            CSR_START_X: start_x_in = csr_wdata;
            CSR_START_Y: start_y_in = csr_wdata;
            default: ;
         endcase
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               // latch the transaction; distance in pixels = 4*fwd + fwd
               dist_in  = (req_fwd_ext <<< 2) + req_fwd_ext;
               yaw_in   = req_tdata[FWD_W +: YAW_W];
               dt_in    = req_tdata[FWD_W+YAW_W +: DT_W];
               state_in = ST_HMUL;
            end
         end
         ST_HMUL: begin
            // dt * yaw_rate on the shared multiplier
            mul_en   = 1'b1;
            state_in = ST_HDIFF;
         end
         ST_HDIFF: begin
            wrap_in  = WRAP_W'(heading_ff) + PI_Q16 - head_step;
            state_in = ST_WRAP;
         end
         ST_WRAP: begin
            // reduce modulo 2*pi, one add or subtract per cycle, then commit the heading and load the CORDIC
            priority if (wrap_ff[WRAP_W-1]) begin
               wrap_in = wrap_ff + TWO_PI_Q16;
            end else if (wrap_ff >= TWO_PI_Q16) begin
               wrap_in = wrap_ff - TWO_PI_Q16;
            end else begin
               heading_in       = heading_new;
               cordic_ctrl.load = 1'b1;
               state_in         = ST_ROT;
            end
         end
         ST_ROT: begin
            cordic_ctrl.step = 1'b1;
            if (cordic_last) begin
               state_in = ST_MULX;
            end
         end
         ST_MULX: begin
            mul_en   = 1'b1;
            mul_a    = dist_ff;
            mul_b    = cos_val;
            state_in = ST_ACCX;
         end
         ST_ACCX: begin
            rel_x_in = rel_x_ff + move_px;
            state_in = ST_MULY;
         end
         ST_MULY: begin
            mul_en   = 1'b1;
            mul_a    = dist_ff;
            mul_b    = sin_val;
            state_in = ST_ACCY;
         end
         ST_ACCY: begin
            rel_y_in = rel_y_ff + move_px;
            state_in = ST_DONE;
         end
         ST_DONE: begin
            // hold until the output register is free, then load the pose
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = {5'b0,
                               heading_ff,
                               rel_y_ff + {4'b0, start_y_ff, 16'b0},
                               rel_x_ff + {4'b0, start_x_ff, 16'b0}};
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // ------------------------------------------------------------------
   // Registers
   // ------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         heading_ff   <= '0;
         rel_x_ff     <= '0;
         rel_y_ff     <= '0;
         start_x_ff   <= START_X_RST;
         start_y_ff   <= START_Y_RST;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         heading_ff   <= heading_in;
         rel_x_ff     <= rel_x_in;
         rel_y_ff     <= rel_y_in;
         start_x_ff   <= start_x_in;
         start_y_ff   <= start_y_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      dist_ff     <= dist_in;
      yaw_ff      <= yaw_in;
      dt_ff       <= dt_in;
      wrap_ff     <= wrap_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule
